>>> src/bnpb_pkg.sv
// ----------------------------------------------------------------------------
// bnpb_pkg
// Shared types, constants and helpers for the breath noise / peaking biquad
// core: controller command and status, register indexes, saturation.
// ----------------------------------------------------------------------------
package bnpb_pkg;

  localparam int unsigned SampleW = 24;
  localparam int unsigned NoiseW  = 16;
  localparam int unsigned CoefW   = 24;
  localparam int unsigned GainW   = 16;
  localparam int unsigned HistW   = 32;
  localparam int unsigned MulAW   = 32;
  localparam int unsigned MulBW   = 26;
  localparam int unsigned ProdW   = MulAW + MulBW;
  localparam int unsigned AccW    = 60;
  localparam int unsigned WideW   = AccW + 1;
  localparam int unsigned CfgIdxW = 3;

  // high-pass round shift, peaking round shift, breath mix round shift
  localparam int unsigned HpShift  = 22;
  localparam int unsigned PkShift  = 20;
  localparam int unsigned MixShift = 8;

  localparam logic signed [CoefW-1:0] PeakB0Reset = 24'sd1048576;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PEAK_B0      = 3'd0,
    REG_PEAK_B1_A1   = 3'd1,
    REG_PEAK_B2      = 3'd2,
    REG_PEAK_A2      = 3'd3,
    REG_HP_A1        = 3'd4,
    REG_HP_A2        = 3'd5,
    REG_BREATH_GAIN  = 3'd6,
    REG_RESONANCE_ON = 3'd7
  } cfg_reg_e;

  // operand pairs of the shared multiplier
  typedef enum logic [3:0] {
    MUL_HP_FF = 4'd0,
    MUL_HP_Y1 = 4'd1,
    MUL_HP_Y2 = 4'd2,
    MUL_MIX   = 4'd3,
    MUL_PK_X0 = 4'd4,
    MUL_PK_X1 = 4'd5,
    MUL_PK_X2 = 4'd6,
    MUL_PK_Y1 = 4'd7,
    MUL_PK_Y2 = 4'd8
  } mul_sel_e;

  typedef enum logic [2:0] {
    ACC_HOLD = 3'd0,
    ACC_LOAD = 3'd1,
    ACC_ADD  = 3'd2,
    ACC_SUB  = 3'd3,
    ACC_SUB4 = 3'd4
  } acc_op_e;

  typedef struct packed {
    logic     start;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     hp_fin;
    logic     mix_fin;
    logic     pk_fin;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic breath_en;
    logic res_en;
    logic out_free;
  } dp_sts_t;

  function automatic logic signed [HistW-1:0] sat32(input logic signed [WideW-1:0] v);
    logic signed [WideW-1:0] hi;
    logic signed [WideW-1:0] lo;
    hi = WideW'(64'sd2147483647);
    lo = WideW'(-64'sd2147483648);
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[HistW-1:0];
  endfunction

  function automatic logic signed [SampleW-1:0] sat24(input logic signed [HistW-1:0] v);
    if (v > 32'sd8388607) begin
      return 24'sh7F_FFFF;
    end else if (v < -32'sd8388608) begin
      return 24'sh80_0000;
    end
    return v[SampleW-1:0];
  endfunction

endpackage

>>> src/bnpb_ctrl.sv
// ----------------------------------------------------------------------------
// bnpb_ctrl
// Sequencer for one item: high-pass terms, breath mix, peaking terms and
// the hand-over to the output register, at most one multiply issued per cycle.
// ----------------------------------------------------------------------------
module bnpb_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  bnpb_pkg::dp_sts_t sts_i,
  output bnpb_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [15:0] {
    ST_IDLE = 16'h0001,
    ST_HP0  = 16'h0002,
    ST_HP1  = 16'h0004,
    ST_HP2  = 16'h0008,
    ST_HP3  = 16'h0010,
    ST_HP4  = 16'h0020,
    ST_MX0  = 16'h0040,
    ST_MX1  = 16'h0080,
    ST_PK0  = 16'h0100,
    ST_PK1  = 16'h0200,
    ST_PK2  = 16'h0400,
    ST_PK3  = 16'h0800,
    ST_PK4  = 16'h1000,
    ST_PK5  = 16'h2000,
    ST_PK6  = 16'h4000,
    ST_OUT  = 16'h8000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d          = state_q;
    cmd_o.start      = 1'b0;
    cmd_o.mul_sel    = bnpb_pkg::MUL_HP_FF;
    cmd_o.acc_op     = bnpb_pkg::ACC_HOLD;
    cmd_o.hp_fin     = 1'b0;
    cmd_o.mix_fin    = 1'b0;
    cmd_o.pk_fin     = 1'b0;
    cmd_o.out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          if (sts_i.breath_en) begin
            state_d = ST_HP0;
          end else if (sts_i.res_en) begin
            state_d = ST_PK0;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_HP0: begin
        cmd_o.mul_sel = bnpb_pkg::MUL_HP_FF;
        state_d       = ST_HP1;
      end
      ST_HP1: begin
        cmd_o.mul_sel = bnpb_pkg::MUL_HP_Y1;
        cmd_o.acc_op  = bnpb_pkg::ACC_LOAD;
        state_d       = ST_HP2;
      end
      ST_HP2: begin
        cmd_o.mul_sel = bnpb_pkg::MUL_HP_Y2;
        cmd_o.acc_op  = bnpb_pkg::ACC_SUB4;
        state_d       = ST_HP3;
      end
      ST_HP3: begin
        cmd_o.acc_op = bnpb_pkg::ACC_SUB4;
        state_d      = ST_HP4;
      end
      ST_HP4: begin
        cmd_o.hp_fin = 1'b1;
        state_d      = ST_MX0;
      end
      ST_MX0: begin
        cmd_o.mul_sel = bnpb_pkg::MUL_MIX;
        state_d       = ST_MX1;
      end
      ST_MX1: begin
        cmd_o.mix_fin = 1'b1;
        state_d       = sts_i.res_en ? ST_PK0 : ST_OUT;
      end
      ST_PK0: begin
        cmd_o.mul_sel = bnpb_pkg::MUL_PK_X0;
        state_d       = ST_PK1;
      end
      ST_PK1: begin
        cmd_o.mul_sel = bnpb_pkg::MUL_PK_X1;
        cmd_o.acc_op  = bnpb_pkg::ACC_LOAD;
        state_d       = ST_PK2;
      end
      ST_PK2: begin
        cmd_o.mul_sel = bnpb_pkg::MUL_PK_X2;
        cmd_o.acc_op  = bnpb_pkg::ACC_ADD;
        state_d       = ST_PK3;
      end
      ST_PK3: begin
        cmd_o.mul_sel = bnpb_pkg::MUL_PK_Y1;
        cmd_o.acc_op  = bnpb_pkg::ACC_ADD;
        state_d       = ST_PK4;
      end
      ST_PK4: begin
        cmd_o.mul_sel = bnpb_pkg::MUL_PK_Y2;
        cmd_o.acc_op  = bnpb_pkg::ACC_SUB;
        state_d       = ST_PK5;
      end
      ST_PK5: begin
        cmd_o.acc_op = bnpb_pkg::ACC_SUB;
        state_d      = ST_PK6;
      end
      ST_PK6: begin
        cmd_o.pk_fin = 1'b1;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        // wait here until the output register can take the item
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/bnpb_dp.sv
// ----------------------------------------------------------------------------
// bnpb_dp
// Datapath: configuration registers, filter histories, one shared 32x26
// multiplier with registered product, 60-bit accumulator and output register.
// ----------------------------------------------------------------------------
module bnpb_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [bnpb_pkg::CfgIdxW-1:0]           cfg_idx_i,
  input  logic [bnpb_pkg::CoefW-1:0]             cfg_data_i,
  input  logic signed [bnpb_pkg::SampleW-1:0]    audio_in_i,
  input  logic signed [bnpb_pkg::NoiseW-1:0]     noise_in_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [bnpb_pkg::SampleW-1:0]   audio_out_o,
  input  bnpb_pkg::dp_cmd_t                      cmd_i,
  output bnpb_pkg::dp_sts_t                      sts_o
);

  localparam int unsigned SW = bnpb_pkg::SampleW;
  localparam int unsigned NW = bnpb_pkg::NoiseW;
  localparam int unsigned CW = bnpb_pkg::CoefW;
  localparam int unsigned HW = bnpb_pkg::HistW;
  localparam int unsigned AW = bnpb_pkg::MulAW;
  localparam int unsigned BW = bnpb_pkg::MulBW;
  localparam int unsigned PW = bnpb_pkg::ProdW;
  localparam int unsigned QW = bnpb_pkg::AccW;
  localparam int unsigned WW = bnpb_pkg::WideW;
  localparam int unsigned DW = NW + 3;

  // configuration
  logic signed [CW-1:0] pk_b0_q, pk_b1a1_q, pk_b2_q, pk_a2_q, hp_a1_q, hp_a2_q;
  logic [bnpb_pkg::GainW-1:0] gain_q;
  logic res_on_q;

  // histories
  logic signed [NW-1:0] hp_x1_q, hp_x2_q;
  logic signed [HW-1:0] hp_y1_q, hp_y2_q;
  logic signed [HW-1:0] pk_x1_q, pk_x2_q, pk_y1_q, pk_y2_q;

  // working registers
  logic signed [SW-1:0] audio_q;
  logic signed [NW-1:0] noise_q;
  logic signed [HW-1:0] hy_q, sum_q;
  logic signed [PW-1:0] prod_q;
  logic signed [QW-1:0] acc_q, acc_d;
  logic signed [SW-1:0] out_q;
  logic out_valid_q;

  logic signed [DW-1:0] hp_diff;
  logic signed [BW-1:0] hp_s;
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [QW-1:0] prod_ext;
  logic signed [WW-1:0] hp_rnd, pk_rnd, mix_rnd, mix_sum;
  logic signed [HW-1:0] hp_y, pk_y, mix_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pk_b0_q   <= bnpb_pkg::PeakB0Reset;
      pk_b1a1_q <= '0;
      pk_b2_q   <= '0;
      pk_a2_q   <= '0;
      hp_a1_q   <= '0;
      hp_a2_q   <= '0;
      gain_q    <= '0;
      res_on_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (bnpb_pkg::cfg_reg_e'(cfg_idx_i))
        bnpb_pkg::REG_PEAK_B0:      pk_b0_q   <= cfg_data_i;
        bnpb_pkg::REG_PEAK_B1_A1:   pk_b1a1_q <= cfg_data_i;
        bnpb_pkg::REG_PEAK_B2:      pk_b2_q   <= cfg_data_i;
        bnpb_pkg::REG_PEAK_A2:      pk_a2_q   <= cfg_data_i;
        bnpb_pkg::REG_HP_A1:        hp_a1_q   <= cfg_data_i;
        bnpb_pkg::REG_HP_A2:        hp_a2_q   <= cfg_data_i;
        bnpb_pkg::REG_BREATH_GAIN:  gain_q    <= cfg_data_i[bnpb_pkg::GainW-1:0];
        bnpb_pkg::REG_RESONANCE_ON: res_on_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign sts_o.breath_en = (gain_q != '0);
  assign sts_o.res_en    = res_on_q;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  // x - 2*x1 + x2 and 4*b0 = 1 - a1 + a2
  assign hp_diff = {{3{noise_q[NW-1]}}, noise_q}
                 - {{2{hp_x1_q[NW-1]}}, hp_x1_q, 1'b0}
                 + {{3{hp_x2_q[NW-1]}}, hp_x2_q};
  assign hp_s = 26'sd1048576
              - {{(BW-CW){hp_a1_q[CW-1]}}, hp_a1_q}
              + {{(BW-CW){hp_a2_q[CW-1]}}, hp_a2_q};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.mul_sel)
      bnpb_pkg::MUL_HP_FF: begin
        mul_a = {{(AW-DW){hp_diff[DW-1]}}, hp_diff};
        mul_b = hp_s;
      end
      bnpb_pkg::MUL_HP_Y1: begin
        mul_a = hp_y1_q;
        mul_b = {{(BW-CW){hp_a1_q[CW-1]}}, hp_a1_q};
      end
      bnpb_pkg::MUL_HP_Y2: begin
        mul_a = hp_y2_q;
        mul_b = {{(BW-CW){hp_a2_q[CW-1]}}, hp_a2_q};
      end
      bnpb_pkg::MUL_MIX: begin
        mul_a = hy_q;
        mul_b = {{(BW-bnpb_pkg::GainW){1'b0}}, gain_q};
      end
      bnpb_pkg::MUL_PK_X0: begin
        mul_a = sum_q;
        mul_b = {{(BW-CW){pk_b0_q[CW-1]}}, pk_b0_q};
      end
      bnpb_pkg::MUL_PK_X1: begin
        mul_a = pk_x1_q;
        mul_b = {{(BW-CW){pk_b1a1_q[CW-1]}}, pk_b1a1_q};
      end
      bnpb_pkg::MUL_PK_X2: begin
        mul_a = pk_x2_q;
        mul_b = {{(BW-CW){pk_b2_q[CW-1]}}, pk_b2_q};
      end
      bnpb_pkg::MUL_PK_Y1: begin
        mul_a = pk_y1_q;
        mul_b = {{(BW-CW){pk_b1a1_q[CW-1]}}, pk_b1a1_q};
      end
      bnpb_pkg::MUL_PK_Y2: begin
        mul_a = pk_y2_q;
        mul_b = {{(BW-CW){pk_a2_q[CW-1]}}, pk_a2_q};
      end
      default: ;
    endcase
  end

  assign prod_ext = {{(QW-PW){prod_q[PW-1]}}, prod_q};

  always_comb begin
    acc_d = acc_q;
    unique case (cmd_i.acc_op)
      bnpb_pkg::ACC_HOLD: acc_d = acc_q;
      bnpb_pkg::ACC_LOAD: acc_d = prod_ext;
      bnpb_pkg::ACC_ADD:  acc_d = acc_q + prod_ext;
      bnpb_pkg::ACC_SUB:  acc_d = acc_q - prod_ext;
      // feedback terms of the high-pass carry a factor of four
      bnpb_pkg::ACC_SUB4: acc_d = acc_q - (prod_ext <<< 2);
      default:            acc_d = acc_q;
    endcase
  end

  // round half up, then saturate
  assign hp_rnd  = ($signed({acc_q[QW-1], acc_q}) + (WW'(1) <<< (bnpb_pkg::HpShift - 1)))
                   >>> bnpb_pkg::HpShift;
  assign pk_rnd  = ($signed({acc_q[QW-1], acc_q}) + (WW'(1) <<< (bnpb_pkg::PkShift - 1)))
                   >>> bnpb_pkg::PkShift;
  assign mix_rnd = ($signed({{(WW-PW){prod_q[PW-1]}}, prod_q})
                    + (WW'(1) <<< (bnpb_pkg::MixShift - 1))) >>> bnpb_pkg::MixShift;
  assign mix_sum = mix_rnd + {{(WW-SW){audio_q[SW-1]}}, audio_q};
  assign hp_y    = bnpb_pkg::sat32(hp_rnd);
  assign pk_y    = bnpb_pkg::sat32(pk_rnd);
  assign mix_y   = bnpb_pkg::sat32(mix_sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_x1_q     <= '0;
      hp_x2_q     <= '0;
      hp_y1_q     <= '0;
      hp_y2_q     <= '0;
      pk_x1_q     <= '0;
      pk_x2_q     <= '0;
      pk_y1_q     <= '0;
      pk_y2_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.hp_fin) begin
        hp_x1_q <= noise_q;
        hp_x2_q <= hp_x1_q;
        hp_y1_q <= hp_y;
        hp_y2_q <= hp_y1_q;
      end
      if (cmd_i.pk_fin) begin
        pk_x1_q <= sum_q;
        pk_x2_q <= pk_x1_q;
        pk_y1_q <= pk_y;
        pk_y2_q <= pk_y1_q;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    acc_q  <= acc_d;
    if (cmd_i.start) begin
      audio_q <= audio_in_i;
      noise_q <= noise_in_i;
      sum_q   <= {{(HW-SW){audio_in_i[SW-1]}}, audio_in_i};
    end else if (cmd_i.mix_fin) begin
      sum_q <= mix_y;
    end else if (cmd_i.pk_fin) begin
      sum_q <= pk_y;
    end
    if (cmd_i.hp_fin) begin
      hy_q <= hp_y;
    end
    if (cmd_i.out_load) begin
      out_q <= bnpb_pkg::sat24(sum_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign audio_out_o = out_q;

endmodule

>>> src/breath_noise_and_peaking_biquad_core.sv
// ----------------------------------------------------------------------------
// breath_noise_and_peaking_biquad_core
// Breath noise high-pass and mix followed by a peaking biquad, Q3.20
// coefficients, one shared multiplier under a sequencing controller.
// ----------------------------------------------------------------------------
//  channel  handshake                fields
//  in       in_valid_i / in_stall_o   audio_in_i[23:0], noise_in_i[15:0]
//  out      out_valid_o / out_stall_i audio_out_o[23:0]
//  cfg      cfg_we_i                  cfg_idx_i[2:0], cfg_data_i[23:0]
//
// an item steps through the high-pass and mix states when breath is on, the peaking
// states when resonance is on, and then the output state; the single 32x26 multiplier
// issues one product a cycle, so the filter terms are formed one after another
// the next item is taken once the current one sits in the output register;
// a stalled output holds the controller in its final state
// reset clears configuration to its defaults and all filter histories
// ----------------------------------------------------------------------------
module breath_noise_and_peaking_biquad_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bnpb_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [bnpb_pkg::CoefW-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [bnpb_pkg::SampleW-1:0] audio_in_i,
  input  logic signed [bnpb_pkg::NoiseW-1:0]  noise_in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [bnpb_pkg::SampleW-1:0] audio_out_o
);

  bnpb_pkg::dp_cmd_t cmd;
  bnpb_pkg::dp_sts_t sts;

  bnpb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bnpb_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .audio_in_i  (audio_in_i),
    .noise_in_i  (noise_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .audio_out_o (audio_out_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

>>> tb/tb_breath_noise_and_peaking_biquad_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_breath_noise_and_peaking_biquad_core
// Drives audio and noise samples through the core and checks every output
// sample against a bit-accurate fixed-point model of the breath high-pass,
// the noise mix and the peaking biquad. Directed cases cover the bypass,
// breath-only, resonance-only and combined paths, history saturation and
// register masking. Randomised phases follow under varying handshake idling.
// ----------------------------------------------------------------------------
module tb_breath_noise_and_peaking_biquad_core;

  localparam int unsigned IdleLimit = 2000;
  localparam longint Max32 = 64'sd2147483647;
  localparam longint Min32 = -64'sd2147483648;
  localparam longint MaxSample = 64'sd8388607;
  localparam longint MinSample = -64'sd8388608;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                cfg_we_i;
  logic [bnpb_pkg::CfgIdxW-1:0]        cfg_idx_i;
  logic [bnpb_pkg::CoefW-1:0]          cfg_data_i;
  logic                                in_valid_i;
  logic                                in_stall_o;
  logic signed [bnpb_pkg::SampleW-1:0] audio_in_i;
  logic signed [bnpb_pkg::NoiseW-1:0]  noise_in_i;
  logic                                out_valid_o;
  logic                                out_stall_i;
  logic signed [bnpb_pkg::SampleW-1:0] audio_out_o;

  // model copy of the register file
  longint pk_b0, pk_b1a1, pk_b2, pk_a2;
  longint hpf_a1, hpf_a2, mix_gain;
  bit     res_on;

  // model filter histories, index 0 is the most recent
  longint hp_x[2], hp_y[2], pk_x[2], pk_y[2];

  logic signed [bnpb_pkg::SampleW-1:0] expected_audio_q[$];
  logic signed [bnpb_pkg::SampleW-1:0] want_audio;

  int unsigned n_errors;
  int unsigned n_samples;
  int unsigned n_results;
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned quiet_cycles;

  breath_noise_and_peaking_biquad_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .audio_in_i (audio_in_i),
    .noise_in_i (noise_in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .audio_out_o(audio_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // add half an lsb, then floor
  function automatic longint round_half_up(longint v, int unsigned n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic logic signed [bnpb_pkg::SampleW-1:0] biquad_predict(
      logic signed [bnpb_pkg::SampleW-1:0] audio, logic signed [bnpb_pkg::NoiseW-1:0] noise);
    longint sum, s, ff, fb, y, acc, r;
    sum = audio;
    if (mix_gain != 0) begin
      // high-pass feed-forward taken from the feedback pair: b0 = b2 = s/4, b1 = -s/2
      s  = (64'sd1 <<< 20) - hpf_a1 + hpf_a2;
      ff = s * (longint'(noise) - 2 * hp_x[0] + hp_x[1]);
      fb = hpf_a1 * hp_y[0] + hpf_a2 * hp_y[1];
      y  = clamp(round_half_up(ff - 4 * fb, bnpb_pkg::HpShift), Min32, Max32);
      hp_x[1] = hp_x[0];
      hp_x[0] = noise;
      hp_y[1] = hp_y[0];
      hp_y[0] = y;
      sum = clamp(longint'(audio) + round_half_up(y * mix_gain, bnpb_pkg::MixShift),
                  Min32, Max32);
    end
    r = sum;
    if (res_on) begin
      acc = pk_b0 * sum + pk_b1a1 * pk_x[0] + pk_b2 * pk_x[1]
          - pk_b1a1 * pk_y[0] - pk_a2 * pk_y[1];
      y = clamp(round_half_up(acc, bnpb_pkg::PkShift), Min32, Max32);
      pk_x[1] = pk_x[0];
      pk_x[0] = sum;
      pk_y[1] = pk_y[0];
      pk_y[0] = y;
      r = y;
    end
    r = clamp(r, MinSample, MaxSample);
    return r[bnpb_pkg::SampleW-1:0];
  endfunction

  function automatic logic [bnpb_pkg::CoefW-1:0] wild_coef();
    case ($urandom_range(3))
      0:       return 24'h80_0000;
      1:       return 24'h7F_FFFF;
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic model_reset();
    pk_b0    = bnpb_pkg::PeakB0Reset;
    pk_b1a1  = 0;
    pk_b2    = 0;
    pk_a2    = 0;
    hpf_a1   = 0;
    hpf_a2   = 0;
    mix_gain = 0;
    res_on   = 1'b0;
    hp_x = '{0, 0};
    hp_y = '{0, 0};
    pk_x = '{0, 0};
    pk_y = '{0, 0};
  endtask

  task automatic write_reg(bnpb_pkg::cfg_reg_e idx, logic [bnpb_pkg::CoefW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      bnpb_pkg::REG_PEAK_B0:      pk_b0    = longint'(signed'(value));
      bnpb_pkg::REG_PEAK_B1_A1:   pk_b1a1  = longint'(signed'(value));
      bnpb_pkg::REG_PEAK_B2:      pk_b2    = longint'(signed'(value));
      bnpb_pkg::REG_PEAK_A2:      pk_a2    = longint'(signed'(value));
      bnpb_pkg::REG_HP_A1:        hpf_a1   = longint'(signed'(value));
      bnpb_pkg::REG_HP_A2:        hpf_a2   = longint'(signed'(value));
      bnpb_pkg::REG_BREATH_GAIN:  mix_gain = longint'(value[bnpb_pkg::GainW-1:0]);
      bnpb_pkg::REG_RESONANCE_ON: res_on   = value[0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_sample(logic signed [bnpb_pkg::SampleW-1:0] audio,
                             logic signed [bnpb_pkg::NoiseW-1:0] noise);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    audio_in_i <= audio;
    noise_in_i <= noise;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    expected_audio_q.push_back(biquad_predict(audio, noise));
    n_samples++;
  endtask

  // lets every outstanding sample come out so the core is idle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_audio_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic randomize_regs();
    int a1v, a2v, lim;
    logic [bnpb_pkg::GainW-1:0] g;
    if ($urandom_range(3) == 0) begin
      write_reg(bnpb_pkg::REG_PEAK_B0, wild_coef());
      write_reg(bnpb_pkg::REG_PEAK_B1_A1, wild_coef());
      write_reg(bnpb_pkg::REG_PEAK_B2, wild_coef());
      write_reg(bnpb_pkg::REG_PEAK_A2, wild_coef());
    end else begin
      // keep the poles inside the stability triangle
      a2v = int'($urandom_range(943718));
      lim = 1048576 + a2v - 65536;
      a1v = int'($urandom_range(2 * lim)) - lim;
      write_reg(bnpb_pkg::REG_PEAK_B0, 24'($urandom_range(2097152, 262144)));
      write_reg(bnpb_pkg::REG_PEAK_B1_A1, 24'(a1v));
      write_reg(bnpb_pkg::REG_PEAK_B2, 24'(int'($urandom_range(2097152)) - 1048576));
      write_reg(bnpb_pkg::REG_PEAK_A2, 24'(a2v));
    end
    if ($urandom_range(3) == 0) begin
      write_reg(bnpb_pkg::REG_HP_A1, wild_coef());
      write_reg(bnpb_pkg::REG_HP_A2, wild_coef());
    end else begin
      a2v = int'($urandom_range(943718));
      lim = 1048576 + a2v - 65536;
      a1v = int'($urandom_range(2 * lim)) - lim;
      write_reg(bnpb_pkg::REG_HP_A1, 24'(a1v));
      write_reg(bnpb_pkg::REG_HP_A2, 24'(a2v));
    end
    case ($urandom_range(4))
      0:       g = '0;
      1:       g = '1;
      2:       g = 16'($urandom_range(255));
      default: g = 16'($urandom());
    endcase
    // upper bits are junk on purpose, the core must mask them
    write_reg(bnpb_pkg::REG_BREATH_GAIN, {8'($urandom()), g});
    write_reg(bnpb_pkg::REG_RESONANCE_ON, 24'($urandom()));
  endtask

  task automatic test_bypass_path();
    send_sample(24'sh7F_FFFF, 16'sh7FFF);
    send_sample(24'sh80_0000, 16'sh8000);
    send_sample(24'sd0, 16'sh7FFF);
    send_sample(-24'sd1, 16'sh8000);
    drain();
  endtask

  task automatic test_breath_path();
    write_reg(bnpb_pkg::REG_HP_A1, -24'sd1900000);
    write_reg(bnpb_pkg::REG_HP_A2, 24'sd860000);
    write_reg(bnpb_pkg::REG_BREATH_GAIN, 24'h00_FFFF);
    send_sample(24'sd0, 16'sh7FFF);
    send_sample(24'sd0, 16'sh8000);
    send_sample(24'sh7F_FFFF, 16'sh7FFF);
    send_sample(24'sh80_0000, 16'sh8000);
    drain();
    write_reg(bnpb_pkg::REG_BREATH_GAIN, 24'h00_0001);
    send_sample(24'sd1000, 16'sh7FFF);
    drain();
    // wildly unstable high-pass, history must pin at the 32-bit rails
    write_reg(bnpb_pkg::REG_HP_A1, 24'h7F_FFFF);
    write_reg(bnpb_pkg::REG_HP_A2, 24'h80_0000);
    write_reg(bnpb_pkg::REG_BREATH_GAIN, 24'h00_FFFF);
    send_sample(24'sd0, 16'sh7FFF);
    send_sample(24'sd0, 16'sh8000);
    send_sample(24'sh7F_FFFF, 16'sh7FFF);
    send_sample(24'sh80_0000, 16'sh8000);
    drain();
  endtask

  task automatic test_resonance_path();
    write_reg(bnpb_pkg::REG_BREATH_GAIN, 24'h00_0000);
    write_reg(bnpb_pkg::REG_PEAK_B0, 24'h7F_FFFF);
    write_reg(bnpb_pkg::REG_PEAK_B1_A1, 24'h80_0000);
    write_reg(bnpb_pkg::REG_PEAK_B2, 24'h7F_FFFF);
    write_reg(bnpb_pkg::REG_PEAK_A2, 24'h80_0000);
    write_reg(bnpb_pkg::REG_RESONANCE_ON, 24'h00_0001);
    send_sample(24'sh7F_FFFF, 16'sh1234);
    send_sample(24'sh80_0000, 16'sh4321);
    send_sample(24'sh7F_FFFF, 16'sh0000);
    send_sample(24'sh80_0000, 16'shFFFF);
    drain();
    write_reg(bnpb_pkg::REG_PEAK_B0, 24'sd1258291);
    write_reg(bnpb_pkg::REG_PEAK_B1_A1, -24'sd1800000);
    write_reg(bnpb_pkg::REG_PEAK_B2, 24'sd600000);
    write_reg(bnpb_pkg::REG_PEAK_A2, 24'sd800000);
    send_sample(24'sd4000000, 16'sh0000);
    send_sample(-24'sd4000000, 16'sh0000);
    send_sample(24'sd123456, 16'sh0000);
    drain();
  endtask

  task automatic test_both_paths();
    write_reg(bnpb_pkg::REG_HP_A1, -24'sd1700000);
    write_reg(bnpb_pkg::REG_HP_A2, 24'sd700000);
    write_reg(bnpb_pkg::REG_BREATH_GAIN, 24'h00_4E20);
    send_sample(24'sd2000000, 16'sh7FFF);
    send_sample(-24'sd3000000, 16'sh8000);
    send_sample(24'sd55555, 16'sh2AAA);
    drain();
  endtask

  task automatic test_register_masking();
    // only bits above the field are set, so breath and resonance both end up off
    write_reg(bnpb_pkg::REG_BREATH_GAIN, 24'hFF_0000);
    write_reg(bnpb_pkg::REG_RESONANCE_ON, 24'hFF_FFFE);
    send_sample(24'sh7F_FFFF, 16'sh7FFF);
    send_sample(-24'sd77, 16'sh8000);
    drain();
  endtask

  task automatic test_random_phase(int unsigned idle_pct, int unsigned stall_pct,
                                   int unsigned n_items);
    logic [bnpb_pkg::SampleW-1:0] aud;
    drain();
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i % 50 == 0) begin
        drain();
        randomize_regs();
      end
      aud = 24'($urandom());
      case ($urandom_range(7))
        0:       aud = 24'h7F_FFFF;
        1:       aud = 24'h80_0000;
        2:       aud = {{12{aud[11]}}, aud[11:0]};
        default: ;
      endcase
      send_sample(aud, 16'($urandom()));
    end
    drain();
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_audio_q.size() == 0) begin
        $display("%0t: audio_out %0d with no sample outstanding", $time, audio_out_o);
        n_errors++;
      end else begin
        want_audio = expected_audio_q.pop_front();
        n_results++;
        if (audio_out_o !== want_audio) begin
          $display("%0t: audio_out mismatch, expected %0d, actual %0d",
                   $time, want_audio, audio_out_o);
          n_errors++;
        end
      end
    end
  end

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      out_stall_i <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("%0t: no item moved for %0d cycles", $time, IdleLimit);
    $display("** breath_noise_and_peaking_biquad_core: FAILED **");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    audio_in_i     = '0;
    noise_in_i     = '0;
    n_errors       = 0;
    n_samples      = 0;
    n_results      = 0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    model_reset();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_bypass_path();
    test_breath_path();
    test_resonance_path();
    test_both_paths();
    test_register_masking();
    test_random_phase(0, 0, 250);
    test_random_phase(58, 0, 250);
    test_random_phase(0, 58, 250);
    test_random_phase(22, 22, 250);

    repeat (20) @(posedge clk_i);
    $display("%0d samples sent, %0d checked: bypass, breath, resonance, both paths,",
             n_samples, n_results);
    $display("rail saturation and register masking under four idle patterns");
    if (n_errors == 0 && expected_audio_q.size() == 0) begin
      $display("** breath_noise_and_peaking_biquad_core: PASSED **");
    end else begin
      $display("** breath_noise_and_peaking_biquad_core: FAILED **");
    end
    $finish;
  end

endmodule
